### sv/assert_macros.svh
// Assertion helpers used by the scanner RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is high.
`define ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

// Next-cycle implication, switched off while reset is high.
`define ASSERT_NXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

### sv/mpds_pkg.sv
// ---------------------------------------------------------------------------
// mpds_pkg
// Types and fixed sizes of the multi-pattern automaton scanner.
// ---------------------------------------------------------------------------
`default_nettype none

package mpds_pkg;

  localparam int STATE_COUNT        = 1024;
  localparam int ALPHABET           = 256;
  localparam int MATCHES_PER_STATE  = 8;
  localparam int MAX_PATTERN_LENGTH = 255;

  localparam int STATE_W = 10;
  localparam int SYM_W   = 8;
  localparam int SLOT_W  = 3;
  localparam int ID_W    = 32;
  localparam int LEN_W   = 8;
  localparam int POS_W   = 20;
  localparam int START_W = 21;
  localparam int COUNT_W = 32;

  localparam int TRANS_DEPTH = STATE_COUNT * ALPHABET;
  localparam int START_MAX   = 2 ** (START_W - 1) - 1;

  typedef enum logic [1:0] {
    FUNC_WR_TRANS = 2'd0,
    FUNC_WR_SLOT  = 2'd1,
    FUNC_SCAN     = 2'd2,
    FUNC_BEGIN    = 2'd3
  } func_t;

  typedef struct packed {
    func_t               func;
    logic [STATE_W-1:0]  state_index;
    logic [SYM_W-1:0]    symbol;
    logic [STATE_W-1:0]  next_state;
    logic [SLOT_W-1:0]   slot;
    logic [ID_W-1:0]     pattern_id;
    logic [LEN_W-1:0]    pattern_length;
    logic                entry_valid;
  } item_t;

  typedef struct packed {
    logic                       match_valid;
    logic [ID_W-1:0]            found_id;
    logic signed [START_W-1:0]  start_index;
    logic [COUNT_W-1:0]         match_count;
    logic [STATE_W-1:0]         current_state;
    logic                       last;
  } result_t;

  typedef struct packed {
    logic              valid;
    logic [ID_W-1:0]   id;
    logic [LEN_W-1:0]  len;
  } slot_entry_t;

  typedef slot_entry_t [MATCHES_PER_STATE-1:0] row_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_TRANS,
    ST_ROW,
    ST_EMIT,
    ST_SLOT_WR
  } fsm_t;

endpackage

`default_nettype wire

### sv/mpds_ram.sv
// ---------------------------------------------------------------------------
// mpds_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data that holds while no read is enabled.
// ---------------------------------------------------------------------------
`default_nettype none

module mpds_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### sv/multi_pattern_dfa_scanner.sv
// ---------------------------------------------------------------------------
// multi_pattern_dfa_scanner
// Aho-Corasick scan engine: transition table and per-state match slots
// held in block RAM, one scanned byte at a time.
// ---------------------------------------------------------------------------
// Usage
//   Command channel: cmd is taken on a rising edge with start high and busy
//   low. Functions: write transition, write match slot, scan byte, begin
//   buffer. Result channel: result is shown for one cycle with result_valid
//   high; the receiver cannot stall it, so it must take every beat.
//   Transition writes and begin items finish in the accepting cycle and
//   give no result. A slot write is a read-modify-write of the state's
//   slot row and keeps busy high while the merged row is written back.
//   A scanned byte reads the transition table, then the slot row of the new
//   state, both registered RAM reads, then sends one result beat per valid
//   slot of the new state (a single beat with no match); one result beat
//   leaves per cycle.
//   The next command can be taken in the cycle the final beat is shown.
//   After reset the slot row RAM is swept to zero, one row per cycle, over
//   all 1024 rows; busy stays high throughout.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module multi_pattern_dfa_scanner (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  mpds_pkg::item_t cmd,
  output logic            busy,
  output logic            result_valid,
  output mpds_pkg::result_t result
);

  import mpds_pkg::*;

  localparam int TRANS_AW = $clog2(TRANS_DEPTH);
  localparam int ROW_W    = $bits(row_t);
  localparam logic signed [POS_W+1:0] StartMaxWide = (POS_W + 2)'(START_MAX);

  fsm_t state, state_next;

  item_t                        cmd_q;
  logic [STATE_W-1:0]           scan_state;
  logic [POS_W-1:0]             byte_position;
  logic [COUNT_W-1:0]           matches_seen;
  logic [STATE_W-1:0]           clr_addr;
  logic [MATCHES_PER_STATE-1:0] pending;
  logic [MATCHES_PER_STATE-1:0] pending_next;

  logic                 accept;
  logic                 trans_we, trans_re;
  logic [TRANS_AW-1:0]  trans_waddr, trans_raddr;
  logic [STATE_W-1:0]   trans_rdata;

  logic                 row_we, row_re;
  logic [STATE_W-1:0]   row_waddr, row_raddr;
  row_t                 row_wdata, row_rdata, row_merged;

  logic [SLOT_W-1:0]          pick;
  logic                       emit_last;
  logic [COUNT_W-1:0]         cnt_inc;
  logic signed [POS_W+1:0]    start_wide;
  logic signed [START_W-1:0]  start_sat;

  assign accept = start && !busy;

  // Transition table: {state, byte} -> next state.
  mpds_ram #(
    .WIDTH (STATE_W),
    .DEPTH (TRANS_DEPTH)
  ) u_trans_ram (
    .clk   (clk),
    .we    (trans_we),
    .waddr (trans_waddr),
    .wdata (cmd.next_state),
    .re    (trans_re),
    .raddr (trans_raddr),
    .rdata (trans_rdata)
  );

  // Match slots: one row of all slots per state.
  mpds_ram #(
    .WIDTH (ROW_W),
    .DEPTH (STATE_COUNT)
  ) u_row_ram (
    .clk   (clk),
    .we    (row_we),
    .waddr (row_waddr),
    .wdata (row_wdata),
    .re    (row_re),
    .raddr (row_raddr),
    .rdata (row_rdata)
  );

  assign trans_waddr = {cmd.state_index, cmd.symbol};
  assign trans_raddr = {scan_state, cmd.symbol};

  // Merge the written slot into the registered slot row read back from RAM.
  always_comb begin
    row_merged = row_rdata;
    row_merged[cmd_q.slot].valid = cmd_q.entry_valid;
    row_merged[cmd_q.slot].id    = cmd_q.pattern_id;
    row_merged[cmd_q.slot].len   =
      (cmd_q.pattern_length > LEN_W'(MAX_PATTERN_LENGTH)) ?
      LEN_W'(MAX_PATTERN_LENGTH) : cmd_q.pattern_length;
  end

  // Lowest pending slot goes out first.
  always_comb begin
    pick = '0;
    for (int i = MATCHES_PER_STATE - 1; i >= 0; i--) begin
      if (pending[i]) begin
        pick = SLOT_W'(i);
      end
    end
    pending_next       = pending;
    pending_next[pick] = 1'b0;
    emit_last          = (pending_next == '0);
  end

  assign cnt_inc = (matches_seen == '1) ? matches_seen : matches_seen + 1'b1;

  always_comb begin
    start_wide = signed'({2'b00, byte_position})
               - signed'({{(POS_W + 2 - LEN_W){1'b0}}, row_rdata[pick].len})
               + signed'((POS_W + 2)'(1));
    start_sat  = (start_wide > StartMaxWide) ? START_W'(StartMaxWide)
                                             : start_wide[START_W-1:0];
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_addr == STATE_W'(STATE_COUNT - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (cmd.func)
            FUNC_SCAN:    state_next = ST_TRANS;
            FUNC_WR_SLOT: state_next = ST_SLOT_WR;
            default:      state_next = ST_IDLE;
          endcase
        end
      end
      ST_TRANS:   state_next = ST_ROW;
      ST_ROW:     state_next = ST_EMIT;
      ST_EMIT: begin
        if (emit_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_SLOT_WR: state_next = ST_IDLE;
      default:    state_next = ST_CLEAR;
    endcase
  end

  // Control outputs per state.
  always_comb begin
    busy      = 1'b1;
    trans_we  = 1'b0;
    trans_re  = 1'b0;
    row_we    = 1'b0;
    row_re    = 1'b0;
    row_waddr = cmd_q.state_index;
    row_wdata = row_merged;
    row_raddr = cmd.state_index;
    case (state)
      ST_CLEAR: begin
        row_we    = 1'b1;
        row_waddr = clr_addr;
        row_wdata = '0;
      end
      ST_IDLE: begin
        busy     = 1'b0;
        trans_we = accept && (cmd.func == FUNC_WR_TRANS);
        trans_re = accept && (cmd.func == FUNC_SCAN);
        row_re   = accept && (cmd.func == FUNC_WR_SLOT);
      end
      ST_TRANS: begin
        row_re    = 1'b1;
        row_raddr = trans_rdata;
      end
      ST_SLOT_WR: begin
        row_we = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      clr_addr      <= '0;
      scan_state    <= '0;
      byte_position <= '0;
      matches_seen  <= '0;
      pending       <= '0;
      result_valid  <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= 1'b0;
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
        end
        ST_IDLE: begin
          if (accept && cmd.func == FUNC_BEGIN) begin
            scan_state    <= cmd.state_index;
            byte_position <= '0;
            matches_seen  <= '0;
          end
        end
        ST_TRANS: begin
          scan_state <= trans_rdata;
        end
        ST_ROW: begin
          for (int i = 0; i < MATCHES_PER_STATE; i++) begin
            pending[i] <= row_rdata[i].valid;
          end
        end
        ST_EMIT: begin
          result_valid <= 1'b1;
          pending      <= pending_next;
          if (pending != '0) begin
            matches_seen <= cnt_inc;
          end
          if (emit_last) begin
            byte_position <= byte_position + 1'b1;
          end
        end
        default: begin
          result_valid <= 1'b0;
        end
      endcase
    end
  end

  // Hold the accepted command and the result payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q <= cmd;
    end
    if (state == ST_EMIT) begin
      result.current_state <= scan_state;
      result.last          <= emit_last;
      if (pending != '0) begin
        result.match_valid <= 1'b1;
        result.found_id    <= row_rdata[pick].id;
        result.start_index <= start_sat;
        result.match_count <= cnt_inc;
      end else begin
        result.match_valid <= 1'b0;
        result.found_id    <= '0;
        result.start_index <= '0;
        result.match_count <= matches_seen;
      end
    end
  end

  `ASSERT_IMP(a_row_we_legal, clk, rst, row_we, (state == ST_CLEAR) || (state == ST_SLOT_WR))
  `ASSERT_NXT(a_scan_to_trans, clk, rst, accept && (cmd.func == FUNC_SCAN), state == ST_TRANS)
  `ASSERT_IMP(a_nonmatch_shape, clk, rst, result_valid && !result.match_valid, result.last && (result.found_id == '0))
  `ASSERT_IMP(a_count_monotone, clk, rst, result_valid && $past(result_valid) && !$past(result.last), result.match_count >= $past(result.match_count))

endmodule

`default_nettype wire
